[design/arcl_pkg.sv]
// ----------------------------------------------------------------------------
// Arc length integrator package
// Shared widths, codes and the lane result type of the arc length integrator.
// ----------------------------------------------------------------------------
package arcl_pkg;

    localparam int COMP_W = 32;
    localparam int DIFF_W = 33;
    localparam int SQ_W   = 66;
    localparam int PROD_W = 64;
    localparam int RAD_W  = 72;
    localparam int ROOT_W = 36;
    localparam int DVD_W  = 64;
    localparam int DVS_W  = 50;
    localparam int ACC_W  = 56;
    localparam int LEN_W  = 48;
    localparam int G_W    = 40;
    localparam int IDX_W  = 13;
    localparam int WT_W   = 6;
    localparam int M_W    = 13;
    localparam int DEN_W  = 18;

    localparam logic [IDX_W-1:0] MAX_SAMPLES = 13'd4096;
    localparam logic [IDX_W-1:0] IDX_MAX     = 13'd8191;

    localparam logic [2:0] METH_CHORD = 3'd0;
    localparam logic [2:0] METH_TRAP  = 3'd1;
    localparam logic [2:0] METH_CORR  = 3'd2;
    localparam logic [2:0] METH_S13   = 3'd3;
    localparam logic [2:0] METH_S38   = 3'd4;
    localparam logic [2:0] METH_BOOLE = 3'd5;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_ZERO_SPEED = 2'd1;
    localparam logic [1:0] ST_FEW        = 2'd2;
    localparam logic [1:0] ST_SAT        = 2'd3;

    localparam logic REG_METHOD = 1'b0;
    localparam logic REG_COUNT  = 1'b1;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic signed [DIFF_W-1:0] diff_t;

    typedef struct packed {
        logic [SQ_W-1:0]          sq;
        logic signed [PROD_W-1:0] prod;
    } lane_out_t;

endpackage

[design/arcl_lane.sv]
// ----------------------------------------------------------------------------
// Arc length lane
// Squares one vector component and forms its velocity times acceleration term.
// ----------------------------------------------------------------------------
module arcl_lane
(
    input  logic                clk,
    input  logic                en,
    input  arcl_pkg::diff_t     c,
    input  arcl_pkg::comp_t     v,
    input  arcl_pkg::comp_t     a,
    output arcl_pkg::lane_out_t res
);
    import arcl_pkg::*;

    logic [DIFF_W-1:0] mag;
    lane_out_t         res_reg;

    assign mag = c[DIFF_W-1] ? DIFF_W'(-c) : DIFF_W'(c);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.sq   <= mag * mag;
            res_reg.prod <= v * a;
        end
    end

    assign res = res_reg;

endmodule

[design/arcl_sqrt.sv]
// ----------------------------------------------------------------------------
// Arc length square root
// Floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module arcl_sqrt
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [arcl_pkg::RAD_W-1:0]  rad,
    output logic                        busy,
    output logic [arcl_pkg::ROOT_W-1:0] root
);
    import arcl_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W+1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic [ROOT_W+1:0] rem_sh;
    logic [ROOT_W+1:0] trial;
    logic              ge;

    assign rem_sh = {rem_reg[ROOT_W-1:0], rad_reg[RAD_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            rad_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(ROOT_W);
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= ge ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], ge};
            cnt_reg  <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

[design/arcl_div.sv]
// ----------------------------------------------------------------------------
// Arc length divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module arcl_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [arcl_pkg::DVD_W-1:0] dvd,
    input  logic [arcl_pkg::DVS_W-1:0] dvs,
    output logic                       busy,
    output logic [arcl_pkg::DVD_W-1:0] quo
);
    import arcl_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DVD_W);
            quo_reg  <= dvd;
            rem_reg  <= '0;
            dvs_reg  <= dvs;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

[design/curve_arc_length_integrator.sv]
// ----------------------------------------------------------------------------
// Curve arc length integrator
// Integrates one curve segment's length from a stream of sampled vectors.
// ----------------------------------------------------------------------------
// Each input word is one sample; the word with tlast closes the segment and
// produces one result word (length Q32.16 and status). Every sample passes the
// square root unit, which resolves one bit per cycle; the corrected trapezoid
// and a closing sample that yields a length also pass the shared divider, which
// also resolves one bit per cycle. A sample is taken only once the last is through.
// The next sample is taken while a finished result still waits on the output.
module curve_arc_length_integrator
#(
    parameter int DIMS = 3
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vec_x, vec_y, vec_z, acc_x, acc_y, acc_z
    input  logic [191:0] s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // segment_length
    output logic [47:0]  m_tdata,
    // status
    output logic [1:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import arcl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LANE, S_MERGE, S_SQRT, S_SQWAIT, S_CDIV, S_CWAIT,
        S_ACC, S_FIN, S_FDIV, S_FWAIT, S_OUT
    } state_t;

    function automatic logic [WT_W-1:0] rule_weight(
        input logic [2:0]       meth,
        input logic [IDX_W-1:0] idx,
        input logic [1:0]       mod3,
        input logic             last
    );
        logic ends;
        logic [WT_W-1:0] w;
        begin
            ends = (idx == '0) || last;
            case (meth) inside
                METH_CHORD:           w = (idx == '0) ? WT_W'(0) : WT_W'(1);
                METH_TRAP, METH_CORR: w = ends ? WT_W'(1) : WT_W'(2);
                METH_S13:             w = ends ? WT_W'(1) : (idx[0] ? WT_W'(4) : WT_W'(2));
                METH_S38:             w = ends ? WT_W'(1) : ((mod3 == 2'd0) ? WT_W'(2) : WT_W'(3));
                METH_BOOLE:
                begin
                    if (ends)
                        w = WT_W'(7);
                    else if (idx[0])
                        w = WT_W'(32);
                    else
                        w = (idx[1:0] == 2'd2) ? WT_W'(12) : WT_W'(14);
                end
                default:              w = '0;
            endcase
            return w;
        end
    endfunction

    // configuration
    logic [2:0]       method_reg;
    logic [IDX_W-1:0] count_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method_reg <= METH_S13;
            count_reg  <= IDX_W'(16);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_METHOD: method_reg <= pwdata[2:0];
                REG_COUNT:  count_reg  <= pwdata[IDX_W-1:0];
                default:    method_reg <= method_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_METHOD: prdata = 32'(method_reg);
            REG_COUNT:  prdata = 32'(count_reg);
            default:    prdata = '0;
        endcase
    end

    // interval count and final divisor for the current registers
    logic [IDX_W-1:0] n_c;
    logic [29:0]      n3_prod;
    logic [M_W-1:0]   m_c;
    logic [DEN_W-1:0] den_c;

    assign n_c     = (count_reg > MAX_SAMPLES) ? MAX_SAMPLES : count_reg;
    assign n3_prod = n_c * 17'd21846;

    always_comb
    begin
        case (method_reg)
            METH_CHORD:
            begin
                m_c   = n_c;
                den_c = DEN_W'(1);
            end
            METH_TRAP:
            begin
                m_c   = n_c;
                den_c = DEN_W'({n_c, 1'b0});
            end
            METH_CORR:
            begin
                m_c   = n_c >> 1;
                den_c = DEN_W'({m_c, 1'b0});
            end
            METH_S13:
            begin
                m_c   = n_c >> 1;
                den_c = DEN_W'(m_c) * DEN_W'(6);
            end
            METH_S38:
            begin
                m_c   = n3_prod[28:16];
                den_c = DEN_W'({m_c, 3'b000});
            end
            METH_BOOLE:
            begin
                m_c   = n_c >> 2;
                den_c = DEN_W'(m_c) * DEN_W'(90);
            end
            default:
            begin
                m_c   = '0;
                den_c = '0;
            end
        endcase
    end

    // sample intake
    comp_t vec_in  [DIMS];
    comp_t acc_in  [DIMS];
    diff_t c_calc  [DIMS];
    comp_t prev_reg[DIMS];
    diff_t c_reg   [DIMS];
    comp_t v_reg   [DIMS];
    comp_t a_reg   [DIMS];

    state_t state_reg;
    logic             accept;
    logic             last_reg;
    logic             first_reg;
    logic [2:0]       meth_reg;
    logic [M_W-1:0]   m_reg;
    logic [DEN_W-1:0] den_reg;
    logic [WT_W-1:0]  wt_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [1:0]       mod3_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [1:0]       flags_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    for (genvar d = 0; d < DIMS; d++)
    begin : g_in
        assign vec_in[d] = s_tdata[COMP_W*d +: COMP_W];
        assign acc_in[d] = s_tdata[COMP_W*(3+d) +: COMP_W];
        assign c_calc[d] = (method_reg == METH_CHORD)
                           ? DIFF_W'(vec_in[d]) - DIFF_W'(prev_reg[d])
                           : DIFF_W'(vec_in[d]);
    end

    // lanes and merge
    lane_out_t lane_res[DIMS];
    logic      lane_en;

    assign lane_en = (state_reg == S_LANE);

    for (genvar d = 0; d < DIMS; d++)
    begin : g_lane
        arcl_lane u_lane
        (
            .clk (clk),
            .en  (lane_en),
            .c   (c_reg[d]),
            .v   (v_reg[d]),
            .a   (a_reg[d]),
            .res (lane_res[d])
        );
    end

    logic [SQ_W+1:0]          sq_sum;
    logic signed [PROD_W:0]   dot_sum;

    always_comb
    begin
        sq_sum  = '0;
        dot_sum = '0;
        for (int d = 0; d < DIMS; d++)
        begin
            sq_sum  = sq_sum + (SQ_W+2)'(lane_res[d].sq);
            dot_sum = dot_sum + $signed({lane_res[d].prod[PROD_W-1], lane_res[d].prod});
        end
    end

    logic [RAD_W-1:0]      rad_reg;
    logic signed [PROD_W:0] dot_reg;

    // shared units
    logic              sqrt_start;
    logic              sqrt_busy;
    logic [ROOT_W-1:0] vel;
    logic              div_start;
    logic              div_busy;
    logic [DVD_W-1:0]  div_q;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DVS_W-1:0]  dvs_reg;

    assign sqrt_start = (state_reg == S_SQRT);
    assign div_start  = (state_reg == S_CDIV) || (state_reg == S_FDIV);

    arcl_sqrt u_sqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .rad   (rad_reg),
        .busy  (sqrt_busy),
        .root  (vel)
    );

    arcl_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .dvd   (dvd_reg),
        .dvs   (dvs_reg),
        .busy  (div_busy),
        .quo   (div_q)
    );

    logic [DVS_W-1:0]  cdvs;
    logic [PROD_W-1:0] dot_mag;
    logic [M_W:0]      dm;

    assign dm      = {m_reg, 1'b0};
    assign cdvs    = vel * dm;
    assign dot_mag = dot_reg[PROD_W] ? PROD_W'(-dot_reg) : PROD_W'(dot_reg);

    // accumulation
    logic signed [G_W-1:0]      g_reg;
    logic signed [G_W+WT_W:0]   wprod;
    logic signed [ACC_W:0]      acc_sum;
    logic                       acc_ovf;
    logic [LEN_W-1:0]           len_reg;
    logic [1:0]                 st_reg;
    logic [LEN_W-1:0]           m_tdata_reg;
    logic [1:0]                 m_tuser_reg;
    logic                       m_tvalid_reg;
    logic                       out_load;

    assign wprod   = g_reg * $signed({1'b0, wt_reg});
    assign acc_sum = $signed({acc_reg[ACC_W-1], acc_reg}) + (ACC_W+1)'(wprod);
    assign acc_ovf = acc_sum[ACC_W] != acc_sum[ACC_W-1];
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            last_reg     <= 1'b0;
            first_reg    <= 1'b0;
            meth_reg     <= '0;
            m_reg        <= '0;
            den_reg      <= '0;
            wt_reg       <= '0;
            idx_reg      <= '0;
            mod3_reg     <= '0;
            acc_reg      <= '0;
            flags_reg    <= '0;
            rad_reg      <= '0;
            dot_reg      <= '0;
            dvd_reg      <= '0;
            dvs_reg      <= '0;
            g_reg        <= '0;
            len_reg      <= '0;
            st_reg       <= ST_OK;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= ST_OK;
            m_tvalid_reg <= 1'b0;
            for (int d = 0; d < DIMS; d++)
            begin
                prev_reg[d] <= '0;
                c_reg[d]    <= '0;
                v_reg[d]    <= '0;
                a_reg[d]    <= '0;
            end
        end
        else
        begin
            if (m_tvalid_reg && m_tready && !out_load)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        for (int d = 0; d < DIMS; d++)
                        begin
                            c_reg[d]    <= c_calc[d];
                            v_reg[d]    <= vec_in[d];
                            a_reg[d]    <= acc_in[d];
                            prev_reg[d] <= vec_in[d];
                        end
                        last_reg  <= s_tlast;
                        first_reg <= (idx_reg == '0);
                        meth_reg  <= method_reg;
                        m_reg     <= m_c;
                        den_reg   <= den_c;
                        wt_reg    <= rule_weight(method_reg, idx_reg, mod3_reg, s_tlast);
                        if (idx_reg != IDX_MAX)
                        begin
                            idx_reg  <= idx_reg + 1'b1;
                            mod3_reg <= (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 1'b1;
                        end
                        state_reg <= S_LANE;
                    end
                end
                S_LANE:
                begin
                    state_reg <= S_MERGE;
                end
                S_MERGE:
                begin
                    rad_reg   <= RAD_W'(sq_sum);
                    dot_reg   <= dot_sum;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    state_reg <= S_SQWAIT;
                end
                S_SQWAIT:
                begin
                    if (!sqrt_busy)
                    begin
                        if ((meth_reg == METH_CHORD) && first_reg)
                        begin
                            g_reg     <= '0;
                            state_reg <= S_ACC;
                        end
                        else if ((meth_reg == METH_CORR) && (vel != '0) && (m_reg != '0))
                        begin
                            g_reg     <= G_W'(vel);
                            dvd_reg   <= dot_mag;
                            dvs_reg   <= cdvs;
                            state_reg <= S_CDIV;
                        end
                        else
                        begin
                            g_reg     <= G_W'(vel);
                            state_reg <= S_ACC;
                            if ((meth_reg == METH_CORR) && (vel == '0))
                            begin
                                flags_reg[0] <= 1'b1;
                            end
                        end
                    end
                end
                S_CDIV:
                begin
                    state_reg <= S_CWAIT;
                end
                S_CWAIT:
                begin
                    if (!div_busy)
                    begin
                        g_reg <= dot_reg[PROD_W]
                                 ? G_W'(vel) - G_W'(div_q[G_W-3:0])
                                 : G_W'(vel) + G_W'(div_q[G_W-3:0]);
                        state_reg <= S_ACC;
                    end
                end
                S_ACC:
                begin
                    if (acc_ovf)
                    begin
                        acc_reg      <= acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                                       : {1'b0, {(ACC_W-1){1'b1}}};
                        flags_reg[1] <= 1'b1;
                    end
                    else
                    begin
                        acc_reg <= acc_sum[ACC_W-1:0];
                    end
                    state_reg <= last_reg ? S_FIN : S_IDLE;
                end
                S_FIN:
                begin
                    if ((m_reg == '0) || (den_reg == '0) || first_reg)
                    begin
                        len_reg   <= '0;
                        st_reg    <= ST_FEW;
                        state_reg <= S_OUT;
                    end
                    else if (acc_reg[ACC_W-1])
                    begin
                        len_reg   <= '0;
                        st_reg    <= ST_SAT;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        dvd_reg   <= DVD_W'(acc_reg[ACC_W-2:0]);
                        dvs_reg   <= DVS_W'(den_reg);
                        state_reg <= S_FDIV;
                    end
                end
                S_FDIV:
                begin
                    state_reg <= S_FWAIT;
                end
                S_FWAIT:
                begin
                    if (!div_busy)
                    begin
                        if (div_q[DVD_W-1:LEN_W] != '0)
                        begin
                            len_reg <= '1;
                            st_reg  <= ST_SAT;
                        end
                        else
                        begin
                            len_reg <= div_q[LEN_W-1:0];
                            st_reg  <= flags_reg[1] ? ST_SAT
                                     : (flags_reg[0] ? ST_ZERO_SPEED : ST_OK);
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        m_tdata_reg  <= len_reg;
                        m_tuser_reg  <= st_reg;
                        m_tvalid_reg <= 1'b1;
                        acc_reg      <= '0;
                        idx_reg      <= '0;
                        mod3_reg     <= '0;
                        flags_reg    <= '0;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_accept_units_free: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (!sqrt_busy && !div_busy))
        else $error("Sample accepted while a shared unit is busy.");

    a_few_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_FEW)) |-> (m_tdata == '0))
        else $error("Too-few-samples result carries a nonzero length.");

    a_segment_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> ((idx_reg == '0) && (acc_reg == '0) && (flags_reg == '0)))
        else $error("Segment state not cleared after a result.");

    a_sqrt_owner: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_busy |-> (state_reg == S_SQWAIT))
        else $error("Square root busy outside its wait state.");

endmodule

[tb/sv/curve_arc_length_integrator_test.sv]
// ----------------------------------------------------------------------------
// Curve arc length integrator testbench
// Streams sampled vectors through every integration method, predicts each
// segment length and status with a bit-exact predictor, and checks every
// result word in order while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module curve_arc_length_integrator_test;

    import arcl_pkg::*;

    localparam logic [2:0] ADDR_METHOD = 3'd0;
    localparam logic [2:0] ADDR_COUNT  = 3'd4;
    localparam logic signed [80:0] ACC_TOP = (81'sd1 <<< 55) - 81'sd1;
    localparam logic signed [80:0] ACC_BOT = -(81'sd1 <<< 55);
    localparam logic [63:0] LEN_TOP = 64'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [31:0] vx, vy, vz, ax, ay, az;
        logic        last;
    } sample_t;

    typedef struct packed {
        logic [47:0] len;
        logic [1:0]  st;
    } seg_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [47:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    seg_result_t       pending_lengths[$];
    int                mismatches;
    int                words_sent;
    int                segments_checked;
    int                hold_cycles;
    bit                calm;

    logic [2:0]        cur_method;
    logic [12:0]       cur_count;
    logic signed [80:0] acc_sum;
    logic signed [32:0] prev_pt[3];
    logic [12:0]       seg_index;
    logic [1:0]        seg_flags;

    curve_arc_length_integrator dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #80_000_000;
        $display("curve_arc_length_integrator_test: done, errors");
        $finish;
    end

    function automatic logic [32:0] mag33(input logic signed [32:0] c);
        return c[32] ? (~c + 33'd1) : c;
    endfunction

    function automatic logic [35:0] vec_norm(input logic signed [32:0] c0, c1, c2);
        logic [71:0] sum;
        logic [71:0] u;
        logic [35:0] r;
        logic [35:0] t;
        sum = '0;
        u = mag33(c0); sum += u * u;
        u = mag33(c1); sum += u * u;
        u = mag33(c2); sum += u * u;
        r = '0;
        for (int b = 35; b >= 0; b--)
        begin
            t = r | (36'd1 << b);
            if ({36'd0, t} * {36'd0, t} <= sum)
                r = t;
        end
        return r;
    endfunction

    function automatic int rule_wt(input logic [2:0] meth, input logic [12:0] idx,
                                   input logic last);
        logic ends;
        ends = (idx == 0) || last;
        case (meth)
            METH_CHORD: return (idx == 0) ? 0 : 1;
            METH_TRAP, METH_CORR: return ends ? 1 : 2;
            METH_S13: return ends ? 1 : (idx[0] ? 4 : 2);
            METH_S38: return ends ? 1 : ((idx % 3) == 0 ? 2 : 3);
            METH_BOOLE:
            begin
                if (ends)
                    return 7;
                if (idx[0])
                    return 32;
                return (idx[1:0] == 2'd2) ? 12 : 14;
            end
            default: return 0;
        endcase
    endfunction

    task automatic predict_length(input sample_t s);
        logic signed [32:0] v[3];
        logic signed [32:0] a[3];
        logic signed [80:0] g;
        logic [12:0] n;
        logic [12:0] m;
        logic [63:0] den;
        logic [35:0] vel;
        logic [65:0] pos;
        logic [65:0] neg;
        logic [65:0] q;
        logic signed [65:0] p;
        logic [63:0] len;
        logic sat;
        seg_result_t r;
        v[0] = $signed(s.vx); v[1] = $signed(s.vy); v[2] = $signed(s.vz);
        a[0] = $signed(s.ax); a[1] = $signed(s.ay); a[2] = $signed(s.az);
        n = (cur_count > 13'd4096) ? 13'd4096 : cur_count;
        case (cur_method)
            METH_CHORD: begin m = n;     den = 64'd1;      end
            METH_TRAP:  begin m = n;     den = 64'd2 * m;  end
            METH_CORR:  begin m = n / 2; den = 64'd2 * m;  end
            METH_S13:   begin m = n / 2; den = 64'd6 * m;  end
            METH_S38:   begin m = n / 3; den = 64'd8 * m;  end
            METH_BOOLE: begin m = n / 4; den = 64'd90 * m; end
            default:    begin m = '0;    den = '0;         end
        endcase
        g = '0;
        if (cur_method == METH_CHORD)
        begin
            if (seg_index != 0)
                g = vec_norm(v[0] - prev_pt[0], v[1] - prev_pt[1], v[2] - prev_pt[2]);
        end
        else if (cur_method <= METH_BOOLE)
        begin
            vel = vec_norm(v[0], v[1], v[2]);
            g = vel;
            if (cur_method == METH_CORR)
            begin
                if (vel == 0)
                    seg_flags[0] = 1'b1;
                else if (m != 0)
                begin
                    pos = '0;
                    neg = '0;
                    for (int i = 0; i < 3; i++)
                    begin
                        p = v[i] * a[i];
                        if (p < 0)
                            neg += -p;
                        else
                            pos += p;
                    end
                    q = ((pos >= neg) ? pos - neg : neg - pos) / ({30'd0, vel} * 2 * m);
                    g = (pos >= neg) ? g + $signed({15'd0, q}) : g - $signed({15'd0, q});
                end
            end
        end
        acc_sum = acc_sum + rule_wt(cur_method, seg_index, s.last) * g;
        if (acc_sum > ACC_TOP)
        begin
            acc_sum = ACC_TOP;
            seg_flags[1] = 1'b1;
        end
        if (acc_sum < ACC_BOT)
        begin
            acc_sum = ACC_BOT;
            seg_flags[1] = 1'b1;
        end
        for (int i = 0; i < 3; i++)
            prev_pt[i] = v[i];
        if (s.last)
        begin
            len = '0;
            if (m == 0 || den == 0 || seg_index == 0)
                r.st = ST_FEW;
            else
            begin
                sat = seg_flags[1];
                if (acc_sum < 0)
                    sat = 1'b1;
                else
                begin
                    len = acc_sum[63:0] / den;
                    if (len > LEN_TOP)
                    begin
                        len = LEN_TOP;
                        sat = 1'b1;
                    end
                end
                r.st = sat ? ST_SAT : (seg_flags[0] ? ST_ZERO_SPEED : ST_OK);
            end
            r.len = len[47:0];
            pending_lengths.push_back(r);
            acc_sum = '0;
            seg_index = '0;
            seg_flags = '0;
        end
        else if (seg_index != 13'd8191)
            seg_index = seg_index + 13'd1;
    endtask

    task automatic send_word(input sample_t s);
        if (!calm && $urandom_range(99) < 36)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 36)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {s.az, s.ay, s.ax, s.vz, s.vy, s.vx};
        s_tlast  <= s.last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_length(s);
        words_sent++;
    endtask

    task automatic drop_valid();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        drop_valid();
        while (pending_lengths.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_METHOD)
            cur_method = data[2:0];
        else
            cur_count = data[12:0];
    endtask

    task automatic apb_check(input logic [2:0] addr, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("register %0d read %h, expected %h", addr, prdata, want);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input logic [2:0] meth, input logic [12:0] cnt);
        wait_drained();
        apb_write(ADDR_METHOD, {29'd0, meth});
        apb_write(ADDR_COUNT, {19'd0, cnt});
        apb_check(ADDR_METHOD, {29'd0, meth});
        apb_check(ADDR_COUNT, {19'd0, cnt});
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3, 4: return $urandom;
            default: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    function automatic sample_t rand_sample(input logic last);
        sample_t s;
        s.vx = rand_comp(); s.vy = rand_comp(); s.vz = rand_comp();
        s.ax = rand_comp(); s.ay = rand_comp(); s.az = rand_comp();
        s.last = last;
        return s;
    endfunction

    task automatic send_segment(input int len);
        for (int i = 0; i < len; i++)
            send_word(rand_sample(i == len - 1));
    endtask

    task automatic test_reset_values();
        apb_check(ADDR_METHOD, {29'd0, METH_S13});
        apb_check(ADDR_COUNT, 32'd16);
        send_segment(5);
        wait_drained();
    endtask

    task automatic test_each_method();
        sample_t s;
        for (int k = 0; k <= 5; k++)
        begin
            configure(k[2:0], (k == 1) ? 13'd4096 : 13'd12);
            s = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0};
            send_word(s);
            s = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0};
            send_word(s);
            send_word('{32'h0001_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1});
            wait_drained();
        end
    endtask

    task automatic test_special_cases();
        configure(METH_TRAP, 13'd8);
        send_segment(1);
        configure(METH_BOOLE, 13'd3);
        send_segment(4);
        configure(3'd6, 13'd16);
        send_segment(3);
        configure(METH_CORR, 13'd1);
        send_segment(3);
        configure(METH_CORR, 13'd8);
        send_word('{32'd0, 32'd0, 32'd0, 32'h1234, 32'd5, 32'd9, 1'b0});
        send_word('{32'h0002_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1});
        send_word('{32'd1, 32'd0, 32'd0, 32'h8000_0000, 32'd0, 32'd0, 1'b0});
        send_word('{32'd1, 32'd0, 32'd0, 32'h8000_0000, 32'd0, 32'd0, 1'b1});
        wait_drained();
        send_segment(2);
        configure(METH_S38, 13'd9);
        send_segment(3);
        wait_drained();
    endtask

    task automatic test_long_segment();
        configure(METH_TRAP, 13'd4096);
        calm = 1'b1;
        for (int i = 0; i < 300; i++)
            send_word('{$urandom_range(65535), 32'd7, 32'd0, 32'd0, 32'd0, 32'd0,
                        i == 299});
        calm = 1'b0;
        wait_drained();
    endtask

    task automatic test_output_stall();
        configure(METH_S13, 13'd6);
        hold_cycles = 3000;
        repeat (8) send_segment(2);
        wait_drained();
    endtask

    task automatic test_random_segments();
        int total;
        int seg;
        total = 0;
        seg = 0;
        while (total < 1100)
        begin
            int len;
            if (seg % 30 == 0)
            begin
                wait_drained();
                configure(($urandom_range(19) == 0) ? 3'($urandom_range(7, 6))
                                                    : 3'($urandom_range(5)),
                          ($urandom_range(9) == 0) ? 13'd4096
                                                   : 13'($urandom_range(24, 1)));
                calm = ($urandom_range(5) == 0);
            end
            len = ($urandom_range(15) == 0) ? $urandom_range(40, 13)
                                            : $urandom_range(12, 1);
            send_segment(len);
            total += len;
            seg++;
        end
        calm = 1'b0;
        wait_drained();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        mismatches  = 0;
        words_sent  = 0;
        segments_checked = 0;
        hold_cycles = 0;
        calm        = 1'b0;
        cur_method  = METH_S13;
        cur_count   = 13'd16;
        acc_sum     = '0;
        prev_pt     = '{default: '0};
        seg_index   = '0;
        seg_flags   = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_each_method();
        test_special_cases();
        test_output_stall();
        test_long_segment();
        test_random_segments();
        $display("Sent %0d sample words and checked %0d segment results,", words_sent,
                 segments_checked);
        $display("covering all six methods, undefined methods, short and long segments "
                 , "and output stalls.");
        if (mismatches == 0)
            $display("curve_arc_length_integrator_test: done, clean");
        else
            $display("curve_arc_length_integrator_test: done, errors");
        $finish;
    end

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
                m_tready <= rst_n && (calm || $urandom_range(99) >= 36);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_lengths.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: length %h status %0d",
                             m_tdata, m_tuser);
            end
            else
            begin
                seg_result_t e;
                e = pending_lengths.pop_front();
                segments_checked++;
                if (m_tdata !== e.len || m_tuser !== e.st)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: length %h status %0d, expected %h %0d",
                                 m_tdata, m_tuser, e.len, e.st);
                end
            end
        end
    end

endmodule
